// File: src/ps2_host_bit_engine_macros.svh
// Assertion helpers for the PS/2 host bit engine.
// Both sample on clk and are disabled while rst is high.
`ifndef PS2_HOST_BIT_ENGINE_MACROS_SVH
`define PS2_HOST_BIT_ENGINE_MACROS_SVH

// Same-cycle implication.
`define PS2_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("ps2 host bit engine check failed");

// Next-cycle implication.
`define PS2_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("ps2 host bit engine check failed");

`endif

// File: src/ps2hbe_pkg.sv
package ps2hbe_pkg;

  typedef enum logic [2:0] {
    PH_LISTEN     = 3'd0,
    PH_RECEIVE    = 3'd1,
    PH_SEND_START = 3'd2,
    PH_SEND       = 3'd3,
    PH_ACK        = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_EDGE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_TICK = 2'd2
  } mode_t;

  localparam logic REG_ACK_BYTE      = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [7:0]  ACK_BYTE_RESET = 8'd250;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd20000;

  localparam logic [3:0] FRAME_CLOCKS = 4'd11;  // rising edge that ends a rx frame
  localparam logic [3:0] LAST_DATA    = 4'd9;   // first index past the data bits
  localparam logic [3:0] PARITY_SLOT  = 4'd9;
  localparam logic [3:0] STOP_SLOT    = 4'd10;
  localparam logic [3:0] ACK_SEEN     = 4'd12;  // marks that the device pulled data low

endpackage

// File: src/ps2_host_bit_engine.sv
// PS/2 host bit engine: one event word in, one status word out.
// Latency: a result word is valid in the cycle after its event word is accepted.
// Throughput: one event word per cycle; the single output register is refilled
//   in the same cycle it is drained, so only a stalled m_tready holds s_tready low.
// Reset (rst, synchronous, active high): listen phase, data line released,
//   ack byte = 250, timeout_ticks = 20000, output register empty.
`include "ps2_host_bit_engine_macros.svh"

module ps2_host_bit_engine (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [0] edge_rising, [1] data_level, [9:2] send_byte
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] data_pull_low, [1] byte_valid, [9:2] received_byte,
                                 // [10] parity_error, [11] is_ack, [12] send_done,
                                 // [13] timed_out, [16:14] phase_now
);
  import ps2hbe_pkg::*;

  // configuration registers
  logic [7:0]  ack_byte;
  logic [15:0] timeout_ticks;

  // engine state
  phase_t      phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic        expect_rising, expect_rising_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic        rx_ones_odd, rx_ones_odd_next;
  logic        rx_parity_bit, rx_parity_bit_next;
  logic [7:0]  tx_shift, tx_shift_next;
  logic        tx_ones_odd, tx_ones_odd_next;
  logic        drive_low, drive_low_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  // decoded event fields
  logic        in_acc;
  logic [1:0]  mode;
  logic        edge_rising;
  logic        data_level;
  logic [7:0]  send_byte;

  // per-event flags
  logic        edge_taken;   // edge direction matches what we wait for
  logic        rx_done;      // eleventh rising edge of a receive frame
  logic        tx_acked;     // rising edge after the device ack
  logic        tick_expire;  // tick reaches the timeout
  logic [16:0] ticks_plus;
  logic [3:0]  bit_inc;

  // result fields
  logic        byte_valid;
  logic [7:0]  received_byte;
  logic        parity_error;
  logic        is_ack;
  logic        send_done;
  logic        timed_out;

  assign mode        = s_tuser;
  assign edge_rising = s_tdata[0];
  assign data_level  = s_tdata[1];
  assign send_byte   = s_tdata[9:2];

  // Output register is free when empty or being drained this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  assign edge_taken = (mode == MODE_EDGE) && (edge_rising == expect_rising);
  assign bit_inc    = bit_index + 4'd1;
  assign ticks_plus = {1'b0, idle_ticks} + 17'd1;
  // A timeout of zero fires on the first tick, which the wide compare gives for free.
  assign tick_expire = (mode == MODE_TICK) && (phase != PH_LISTEN) &&
                       (ticks_plus >= {1'b0, timeout_ticks});

  // Configuration writes; a word accepted in the same cycle still sees the old value.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_byte      <= ACK_BYTE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACK_BYTE:      ack_byte      <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic for the whole engine.
  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    expect_rising_next = expect_rising;
    rx_shift_next      = rx_shift;
    rx_ones_odd_next   = rx_ones_odd;
    rx_parity_bit_next = rx_parity_bit;
    tx_shift_next      = tx_shift;
    tx_ones_odd_next   = tx_ones_odd;
    drive_low_next     = drive_low;
    idle_ticks_next    = idle_ticks;

    unique case (mode)
      MODE_EDGE: begin
        // An edge of the wrong direction is ignored entirely.
        if (edge_taken) begin
          idle_ticks_next = '0;
          unique case (phase)
            PH_LISTEN: begin
              // falling edge of the start bit
              bit_index_next     = '0;
              rx_ones_odd_next   = 1'b0;
              expect_rising_next = 1'b1;
              phase_next         = PH_RECEIVE;
            end
            PH_RECEIVE: begin
              if (edge_rising) begin
                bit_index_next     = bit_inc;
                if (bit_inc >= FRAME_CLOCKS) phase_next = PH_LISTEN;
                expect_rising_next = 1'b0;
              end else begin
                // sample on the falling edge: data LSB first, then parity
                if ((bit_index != 4'd0) && (bit_index < LAST_DATA)) begin
                  rx_shift_next    = {data_level, rx_shift[7:1]};
                  rx_ones_odd_next = rx_ones_odd ^ data_level;
                end else if (bit_index == PARITY_SLOT) begin
                  rx_parity_bit_next = data_level;
                end
                expect_rising_next = 1'b1;
              end
            end
            PH_SEND_START: begin
              // device clocked in our start bit
              bit_index_next   = '0;
              tx_ones_odd_next = 1'b0;
              phase_next       = PH_SEND;
            end
            PH_SEND: begin
              bit_index_next = bit_inc;
              if (bit_inc < LAST_DATA) begin
                drive_low_next   = !tx_shift[0];
                tx_ones_odd_next = tx_ones_odd ^ tx_shift[0];
                tx_shift_next    = {1'b0, tx_shift[7:1]};
              end else if (bit_inc == PARITY_SLOT) begin
                // odd parity: pull low when the data already had an odd count
                drive_low_next = tx_ones_odd;
                bit_index_next = STOP_SLOT;
              end else begin
                drive_low_next = 1'b0;  // release for the stop bit
                phase_next     = PH_ACK;
              end
            end
            PH_ACK: begin
              if (edge_rising) begin
                expect_rising_next = 1'b0;
                if (bit_index >= ACK_SEEN) phase_next = PH_LISTEN;
              end else begin
                if (!data_level) bit_index_next = ACK_SEEN;
                expect_rising_next = 1'b1;
              end
            end
            default: begin
              phase_next         = PH_LISTEN;
              expect_rising_next = 1'b0;
              drive_low_next     = 1'b0;
              idle_ticks_next    = '0;
            end
          endcase
        end
      end
      MODE_SEND: begin
        // a send request aborts whatever is in progress
        tx_shift_next      = send_byte;
        bit_index_next     = '0;
        expect_rising_next = 1'b0;
        drive_low_next     = 1'b1;
        idle_ticks_next    = '0;
        phase_next         = PH_SEND_START;
      end
      MODE_TICK: begin
        if (phase == PH_LISTEN) begin
          idle_ticks_next = '0;
        end else if (tick_expire) begin
          phase_next         = PH_LISTEN;
          expect_rising_next = 1'b0;
          drive_low_next     = 1'b0;
          idle_ticks_next    = '0;
        end else begin
          idle_ticks_next = ticks_plus[15:0];
        end
      end
      default: ;  // unused mode changes nothing
    endcase
  end

  // Result fields for the accepted event.
  always_comb begin
    rx_done  = edge_taken && (phase == PH_RECEIVE) && edge_rising &&
               (bit_inc >= FRAME_CLOCKS);
    tx_acked = edge_taken && (phase == PH_ACK) && edge_rising && (bit_index >= ACK_SEEN);

    byte_valid    = rx_done;
    received_byte = rx_done ? rx_shift : 8'd0;
    // odd parity over data plus parity bit must come out odd
    parity_error  = rx_done && !(rx_ones_odd ^ rx_parity_bit);
    is_ack        = rx_done && (rx_shift == ack_byte);
    send_done     = tx_acked;
    timed_out     = tick_expire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LISTEN;
      bit_index     <= '0;
      expect_rising <= 1'b0;
      rx_shift      <= '0;
      rx_ones_odd   <= 1'b0;
      rx_parity_bit <= 1'b0;
      tx_shift      <= '0;
      tx_ones_odd   <= 1'b0;
      drive_low     <= 1'b0;
      idle_ticks    <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      expect_rising <= expect_rising_next;
      rx_shift      <= rx_shift_next;
      rx_ones_odd   <= rx_ones_odd_next;
      rx_parity_bit <= rx_parity_bit_next;
      tx_shift      <= tx_shift_next;
      tx_ones_odd   <= tx_ones_odd_next;
      drive_low     <= drive_low_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  // Result register: holds one word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_tdata <= {7'd0, phase_next, timed_out, send_done, is_ack, parity_error,
                  received_byte, byte_valid, drive_low_next};
    end
  end

  // A completed frame lands in listen with its result pending.
  `PS2_ASSERT_NEXT(a_rx_done_listen, in_acc && rx_done,
                   phase == PH_LISTEN && m_tvalid && m_tdata[1])
  // A send request starts the frame with the start bit driven.
  `PS2_ASSERT_NEXT(a_send_start, in_acc && mode == MODE_SEND,
                   phase == PH_SEND_START && drive_low && idle_ticks == 16'd0)
  // Timeout releases the line and returns to listen.
  `PS2_ASSERT_NEXT(a_timeout_release, in_acc && tick_expire,
                   phase == PH_LISTEN && !drive_low && idle_ticks == 16'd0 && m_tdata[13])
  // The engine never pulls data low while listening.
  `PS2_ASSERT_NOW(a_listen_released, phase == PH_LISTEN, !drive_low)

endmodule
